@@ src/ssva_pkg.sv @@
// ---------------------------------------------------------------------------
// Slot pool allocator package
// Shared constants, codes and types of the slot pool allocator.
// ---------------------------------------------------------------------------
package ssva_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int DATA_W  = 8;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CNT_W-1:0] THRESHOLD_RESET = CNT_W'(3);

  // Register index of the configuration port.
  localparam logic [PADDR_W-3:0] REG_WAIT_THRESHOLD = '0;

  typedef enum logic [ACT_W-1:0] {
    ACT_BEGIN_PRODUCE  = 3'd0,
    ACT_FINISH_PRODUCE = 3'd1,
    ACT_BEGIN_CONSUME  = 3'd2,
    ACT_FINISH_CONSUME = 3'd3,
    ACT_QUERY          = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_WOULDWAIT = 2'd1,
    STAT_BADSLOT   = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } fsm_t;

  // Command from the front end to the slot tracker.
  typedef struct packed {
    logic              valid;
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] slot;
  } trk_cmd_t;

  // Decision of the slot tracker for the current command.
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_out;
    logic [CNT_W-1:0]  full_count;
    logic [CNT_W-1:0]  free_count;
    logic              produce_ok;
    logic              consume_ok;
  } trk_res_t;

endpackage

@@ src/ssva_in_if.sv @@
// ---------------------------------------------------------------------------
// Slot pool allocator input channel
// Valid/ready channel carrying one action request.
// ---------------------------------------------------------------------------
interface ssva_in_if;
  logic                         valid;
  logic                         ready;
  logic [ssva_pkg::ACT_W-1:0]   action;
  logic [ssva_pkg::SLOT_W-1:0]  slot;
  logic [ssva_pkg::DATA_W-1:0]  data;

  modport source (output valid, action, slot, data, input ready);
  modport sink (input valid, action, slot, data, output ready);
endinterface

@@ src/ssva_out_if.sv @@
// ---------------------------------------------------------------------------
// Slot pool allocator output channel
// Valid/ready channel carrying one action result.
// ---------------------------------------------------------------------------
interface ssva_out_if;
  logic                         valid;
  logic                         ready;
  logic [ssva_pkg::STAT_W-1:0]  status;
  logic [ssva_pkg::SLOT_W-1:0]  slot_out;
  logic [ssva_pkg::DATA_W-1:0]  data_out;
  logic [ssva_pkg::CNT_W-1:0]   full_count;
  logic [ssva_pkg::CNT_W-1:0]   free_count;

  modport source (output valid, status, slot_out, data_out, full_count, free_count,
                  input ready);
  modport sink (input valid, status, slot_out, data_out, full_count, free_count,
                output ready);
endinterface

@@ src/ssva_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module ssva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/ssva_tracker.sv @@
// ---------------------------------------------------------------------------
// Slot state tracker
// Free and full flags per slot, the two slot counters, and the priority
// encoders that pick the lowest free or full slot.
// ---------------------------------------------------------------------------
module ssva_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  ssva_pkg::trk_cmd_t          cmd,
  input  logic [ssva_pkg::CNT_W-1:0]  threshold,
  output ssva_pkg::trk_res_t          res
);

  // A slot with neither flag set is in use.
  logic [ssva_pkg::SLOTS-1:0]  free_vec, free_vec_next;
  logic [ssva_pkg::SLOTS-1:0]  full_vec, full_vec_next;
  logic [ssva_pkg::CNT_W-1:0]  free_cnt, free_cnt_next;
  logic [ssva_pkg::CNT_W-1:0]  full_cnt, full_cnt_next;

  logic                        free_found, full_found;
  logic [ssva_pkg::SLOT_W-1:0] free_idx, full_idx;
  logic                        slot_busy;

  // Scanning from the top down leaves the lowest matching index.
  always_comb begin
    free_found = 1'b0;
    full_found = 1'b0;
    free_idx   = '0;
    full_idx   = '0;
    for (int i = ssva_pkg::SLOTS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_found = 1'b1;
        free_idx   = ssva_pkg::SLOT_W'(i);
      end
      if (full_vec[i]) begin
        full_found = 1'b1;
        full_idx   = ssva_pkg::SLOT_W'(i);
      end
    end
  end

  assign slot_busy = (ssva_pkg::CNT_W'(cmd.slot) < ssva_pkg::CNT_W'(ssva_pkg::SLOTS))
                     && !free_vec[cmd.slot] && !full_vec[cmd.slot];

  always_comb begin
    free_vec_next  = free_vec;
    full_vec_next  = full_vec;
    free_cnt_next  = free_cnt;
    full_cnt_next  = full_cnt;
    res.status     = ssva_pkg::STAT_OK;
    res.slot_out   = '0;
    res.produce_ok = 1'b0;
    res.consume_ok = 1'b0;
    case (cmd.action)
      ssva_pkg::ACT_BEGIN_PRODUCE: begin
        if (free_found) begin
          free_vec_next[free_idx] = 1'b0;
          free_cnt_next           = free_cnt - 1'b1;
          res.slot_out            = free_idx;
        end else begin
          res.status = ssva_pkg::STAT_WOULDWAIT;
        end
      end
      ssva_pkg::ACT_FINISH_PRODUCE: begin
        res.slot_out = cmd.slot;
        if (slot_busy) begin
          full_vec_next[cmd.slot] = 1'b1;
          full_cnt_next           = full_cnt + 1'b1;
          res.produce_ok          = 1'b1;
        end else begin
          res.status = ssva_pkg::STAT_BADSLOT;
        end
      end
      ssva_pkg::ACT_BEGIN_CONSUME: begin
        if (full_found) begin
          full_vec_next[full_idx] = 1'b0;
          full_cnt_next           = full_cnt - 1'b1;
          res.slot_out            = full_idx;
        end else begin
          res.status = ssva_pkg::STAT_WOULDWAIT;
        end
      end
      ssva_pkg::ACT_FINISH_CONSUME: begin
        res.slot_out = cmd.slot;
        if (slot_busy) begin
          free_vec_next[cmd.slot] = 1'b1;
          free_cnt_next           = free_cnt + 1'b1;
          res.consume_ok          = 1'b1;
        end else begin
          res.status = ssva_pkg::STAT_BADSLOT;
        end
      end
      ssva_pkg::ACT_QUERY: begin
        res.status = (full_cnt < threshold) ? ssva_pkg::STAT_WOULDWAIT
                                            : ssva_pkg::STAT_OK;
      end
      default: begin
        res.status = ssva_pkg::STAT_OK;
      end
    endcase
    res.full_count = full_cnt_next;
    res.free_count = free_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_vec <= '1;
      full_vec <= '0;
      free_cnt <= ssva_pkg::CNT_W'(ssva_pkg::SLOTS);
      full_cnt <= '0;
    end else if (cmd.valid) begin
      free_vec <= free_vec_next;
      full_vec <= full_vec_next;
      free_cnt <= free_cnt_next;
      full_cnt <= full_cnt_next;
    end
  end

endmodule

@@ src/slot_state_vector_allocator_top.sv @@
// ---------------------------------------------------------------------------
// Slot pool allocator, top level
// Producer/consumer byte slot pool with begin/finish actions and a query.
// ---------------------------------------------------------------------------
// Every action gives one result. Begin produce, finish produce, begin
// consume, query and rejected finish actions show their result in the
// cycle after acceptance; a successful finish consume first passes the
// registered RAM read and the read state to fetch the slot byte. A new
// transaction is accepted once the output register is empty or being
// emptied in the same cycle, so the block sustains one action per cycle
// while the output side is ready, but takes none in the read state.
// Slot flags and counters live in flip-flops and are ready right after
// reset; slot bytes are undefined until a finish produce writes them.
module slot_state_vector_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  ssva_in_if.sink                       in_ch,
  ssva_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssva_pkg::PADDR_W-1:0]  paddr,
  input  logic [ssva_pkg::PDATA_W-1:0]  pwdata,
  output logic [ssva_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  ssva_pkg::fsm_t                state, state_next;
  logic [ssva_pkg::CNT_W-1:0]    wait_threshold;
  logic                          in_take;
  logic                          reg_sel;
  ssva_pkg::trk_cmd_t            cmd;
  ssva_pkg::trk_res_t            res;
  logic [ssva_pkg::DATA_W-1:0]   ram_rdata;

  logic                          out_valid;
  logic [ssva_pkg::STAT_W-1:0]   out_status;
  logic [ssva_pkg::SLOT_W-1:0]   out_slot;
  logic [ssva_pkg::DATA_W-1:0]   out_data;
  logic [ssva_pkg::CNT_W-1:0]    out_full;
  logic [ssva_pkg::CNT_W-1:0]    out_free;

  // Configuration port.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ssva_pkg::PADDR_W-1:2] == ssva_pkg::REG_WAIT_THRESHOLD);
  assign prdata  = reg_sel ? ssva_pkg::PDATA_W'(wait_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_threshold <= ssva_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      wait_threshold <= pwdata[ssva_pkg::CNT_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ssva_pkg::ST_IDLE: begin
        if (in_take && res.consume_ok) begin
          state_next = ssva_pkg::ST_READ;
        end
      end
      ssva_pkg::ST_READ: begin
        state_next = ssva_pkg::ST_IDLE;
      end
      default: begin
        state_next = ssva_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    case (state)
      ssva_pkg::ST_IDLE: in_ch.ready = !out_valid || out_ch.ready;
      default:           in_ch.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssva_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_take    = in_ch.valid && in_ch.ready;
  assign cmd.valid  = in_take;
  assign cmd.action = in_ch.action;
  assign cmd.slot   = in_ch.slot;

  ssva_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .threshold (wait_threshold),
    .res       (res)
  );

  ssva_ram #(
    .WIDTH (ssva_pkg::DATA_W),
    .DEPTH (ssva_pkg::SLOTS)
  ) u_data_ram (
    .clk   (clk),
    .we    (in_take && res.produce_ok),
    .waddr (in_ch.slot),
    .wdata (in_ch.data),
    .raddr (in_ch.slot),
    .rdata (ram_rdata)
  );

  // Output register. A successful finish consume waits in the read state for
  // the registered RAM byte before the result is shown.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= !res.consume_ok;
    end else if (state == ssva_pkg::ST_READ) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_status <= res.status;
      out_slot   <= res.slot_out;
      out_data   <= '0;
      out_full   <= res.full_count;
      out_free   <= res.free_count;
    end else if (state == ssva_pkg::ST_READ) begin
      out_data   <= ram_rdata;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.status     = out_status;
  assign out_ch.slot_out   = out_slot;
  assign out_ch.data_out   = out_data;
  assign out_ch.full_count = out_full;
  assign out_ch.free_count = out_free;

endmodule

@@ tb/testbench.sv @@
// ---------------------------------------------------------------------------
// Slot pool allocator testbench
// Drives begin/finish produce, begin/finish consume, query and unused action
// codes through the valid/ready input channel. The expected results come
// from a cycle-free model of the slot flags, bytes and counters that is
// kept in step with every accepted transaction. Results are checked in
// order while the output side stalls on its own pattern. The wait threshold
// is rewritten and read back over the register port between phases.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssva_pkg::*;

  localparam logic [PADDR_W-1:0] THRESHOLD_ADDR   = {REG_WAIT_THRESHOLD, 2'b00};
  localparam logic [ACT_W-1:0]   ACT_FIRST_UNUSED = 3'd5;
  localparam logic [ACT_W-1:0]   ACT_LAST_UNUSED  = 3'd7;

  typedef enum logic [1:0] {
    SLOT_FREE,
    SLOT_BUSY,
    SLOT_FULL
  } slot_mark_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_out;
    logic [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]  full_count;
    logic [CNT_W-1:0]  free_count;
  } pool_result_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  ssva_in_if  in_ch ();
  ssva_out_if out_ch ();

  slot_state_vector_allocator_top dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Model of the pool as the block should see it.
  slot_mark_t        slot_mark [SLOTS];
  logic [DATA_W-1:0] slot_byte [SLOTS];
  bit                byte_written [SLOTS];
  logic [CNT_W-1:0]  free_left;
  logic [CNT_W-1:0]  full_now;
  logic [CNT_W-1:0]  threshold_now;

  pool_result_t expected_results [$];

  int errors;
  int items_sent;
  int results_checked;
  int burst_left;
  int produce_blocked;
  int consume_blocked;
  int query_passed;
  int wrong_state_finishes;
  int thresholds_used;

  int          stall_mode;
  int          mode_timer;
  logic [15:0] stall_pattern;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one action to the pool model and returns the result it gives.
  function automatic pool_result_t apply_action(input logic [ACT_W-1:0]  act,
                                                input logic [SLOT_W-1:0] slot,
                                                input logic [DATA_W-1:0] data);
    pool_result_t res;
    slot_mark_t   wanted;
    int           pick;
    res = '0;
    res.status = STAT_OK;
    case (act)
      ACT_BEGIN_PRODUCE, ACT_BEGIN_CONSUME: begin
        wanted = (act == ACT_BEGIN_PRODUCE) ? SLOT_FREE : SLOT_FULL;
        pick = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (slot_mark[i] == wanted) pick = i;
        end
        if (pick < 0) begin
          res.status = STAT_WOULDWAIT;
          if (act == ACT_BEGIN_PRODUCE) produce_blocked++;
          else consume_blocked++;
        end else begin
          slot_mark[pick] = SLOT_BUSY;
          if (act == ACT_BEGIN_PRODUCE) free_left--;
          else full_now--;
          res.slot_out = SLOT_W'(pick);
        end
      end
      ACT_FINISH_PRODUCE, ACT_FINISH_CONSUME: begin
        res.slot_out = slot;
        if (slot_mark[slot] != SLOT_BUSY) begin
          res.status = STAT_BADSLOT;
          wrong_state_finishes++;
        end else if (act == ACT_FINISH_PRODUCE) begin
          slot_byte[slot] = data;
          byte_written[slot] = 1'b1;
          slot_mark[slot] = SLOT_FULL;
          full_now++;
        end else begin
          res.data_out = slot_byte[slot];
          slot_mark[slot] = SLOT_FREE;
          free_left++;
        end
      end
      ACT_QUERY: begin
        if (full_now < threshold_now) begin
          res.status = STAT_WOULDWAIT;
        end else begin
          query_passed++;
        end
      end
      default: ;
    endcase
    res.full_count = full_now;
    res.free_count = free_left;
    return res;
  endfunction

  task automatic send_action(input logic [ACT_W-1:0]  act,
                             input logic [SLOT_W-1:0] slot,
                             input logic [DATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.slot   <= slot;
    in_ch.data   <= data;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(apply_action(act, slot, data));
    items_sent++;
  endtask

  // Lets every pending result come back, then waits further so the
  // block is idle for a register access.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_threshold(input logic [CNT_W-1:0] value);
    drain_results();
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= THRESHOLD_ADDR;
    pwdata  <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    threshold_now = value;
    thresholds_used++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[CNT_W-1:0] !== value) begin
      $error("wait_threshold readback: expected %0d, got %0d", value, prdata[CNT_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Nothing to claim and nothing to finish on an empty pool.
  task automatic test_empty_pool();
    send_action(ACT_QUERY, 4'h0, 8'h00);
    send_action(ACT_BEGIN_CONSUME, 4'h0, 8'h00);
    send_action(ACT_FINISH_PRODUCE, 4'hF, 8'hFF);
    send_action(ACT_FINISH_CONSUME, 4'h0, 8'h00);
    send_action(ACT_FIRST_UNUSED, 4'h0, 8'h00);
    send_action(ACT_LAST_UNUSED, 4'hF, 8'hFF);
  endtask

  // Claim every slot, then one more begin produce has to wait.
  task automatic test_exhaust_pool();
    repeat (SLOTS + 1) send_action(ACT_BEGIN_PRODUCE, 4'h0, 8'h00);
    send_action(ACT_QUERY, 4'h0, 8'h00);
  endtask

  // A slot claimed by a consumer can be finished as a produce, since there
  // is only one in-use mark.
  task automatic test_slot_reuse();
    send_action(ACT_FINISH_PRODUCE, 4'h0, 8'hFF);
    send_action(ACT_FINISH_PRODUCE, 4'hF, 8'h00);
    send_action(ACT_BEGIN_CONSUME, 4'h0, 8'h00);
    send_action(ACT_FINISH_PRODUCE, 4'h0, 8'hA5);
    send_action(ACT_BEGIN_CONSUME, 4'h0, 8'h00);
    send_action(ACT_FINISH_CONSUME, 4'h0, 8'h00);
    send_action(ACT_FINISH_CONSUME, 4'h0, 8'h00);
    send_action(ACT_QUERY, 4'h0, 8'h00);
  endtask

  // Mostly well-formed begin/finish pairs on claimed slots, with queries,
  // stray finishes and unused codes mixed in. produce_pct steers the fill.
  task automatic test_random_traffic(input int count, input int produce_pct);
    logic [ACT_W-1:0]  act;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] data;
    int                busy [$];
    int                r;
    int                target;
    for (int n = 0; n < count; n++) begin
      r    = $urandom_range(0, 99);
      slot = SLOT_W'($urandom);
      data = DATA_W'($urandom);
      busy.delete();
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_mark[i] == SLOT_BUSY) busy.push_back(i);
      end
      target = (busy.size() != 0) ? busy[$urandom_range(0, busy.size() - 1)] : -1;
      if (r < 4) begin
        act = ACT_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
      end else if (r < 10) begin
        act = $urandom_range(0, 1) ? ACT_FINISH_PRODUCE : ACT_FINISH_CONSUME;
      end else if (r < 18) begin
        act = ACT_QUERY;
      end else if ($urandom_range(0, 99) < produce_pct) begin
        if (target >= 0 && $urandom_range(0, 1)) begin
          act  = ACT_FINISH_PRODUCE;
          slot = SLOT_W'(target);
        end else begin
          act = ACT_BEGIN_PRODUCE;
        end
      end else begin
        if (target >= 0 && byte_written[target] && $urandom_range(0, 1)) begin
          act  = ACT_FINISH_CONSUME;
          slot = SLOT_W'(target);
        end else begin
          act = ACT_BEGIN_CONSUME;
        end
      end
      // A slot whose byte was never written must not be consumed.
      if (act == ACT_FINISH_CONSUME && slot_mark[slot] == SLOT_BUSY && !byte_written[slot])
        act = ACT_FINISH_PRODUCE;
      send_action(act, slot, data);
    end
  endtask

  task automatic check_result();
    pool_result_t want;
    if (expected_results.size() == 0) begin
      $error("result with no pending transaction: status %0d slot_out %0d",
             out_ch.status, out_ch.slot_out);
      errors++;
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (out_ch.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_ch.status);
        errors++;
      end
      if (out_ch.slot_out !== want.slot_out) begin
        $error("slot_out: expected %0d, got %0d", want.slot_out, out_ch.slot_out);
        errors++;
      end
      if (out_ch.data_out !== want.data_out) begin
        $error("data_out: expected %0d, got %0d", want.data_out, out_ch.data_out);
        errors++;
      end
      if (out_ch.full_count !== want.full_count) begin
        $error("full_count: expected %0d, got %0d", want.full_count, out_ch.full_count);
        errors++;
      end
      if (out_ch.free_count !== want.free_count) begin
        $error("free_count: expected %0d, got %0d", want.free_count, out_ch.free_count);
        errors++;
      end
    end
  endtask

  // Output side: checks every transaction and stalls in changing modes.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      mode_timer = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (mode_timer == 0) begin
        stall_mode    = $urandom_range(0, 3);
        mode_timer    = $urandom_range(20, 150);
        stall_pattern = 16'($urandom) | 16'h0001;
      end
      mode_timer--;
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 9) < 7);
        2: begin
          stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
          out_ch.ready <= stall_pattern[0];
        end
        default: out_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= '0;
    in_ch.slot   <= '0;
    in_ch.data   <= '0;
    clk = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_mark[i]    = SLOT_FREE;
      slot_byte[i]    = '0;
      byte_written[i] = 1'b0;
    end
    free_left     = CNT_W'(SLOTS);
    full_now      = '0;
    threshold_now = THRESHOLD_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_pool();
    test_exhaust_pool();
    test_slot_reuse();

    set_threshold(5'd0);
    test_random_traffic(300, 55);
    set_threshold(5'd16);
    test_random_traffic(300, 75);
    set_threshold(5'd17);
    test_random_traffic(250, 60);
    set_threshold(5'd1);
    test_random_traffic(250, 35);
    set_threshold(5'd8);
    test_random_traffic(300, 50);
    set_threshold(5'd15);
    test_random_traffic(250, 65);

    drain_results();
    $display("Sent %0d actions, checked %0d results under %0d threshold settings.",
             items_sent, results_checked, thresholds_used);
    $display("Pool full %0d times, empty %0d times, %0d queries passed, %0d bad finishes.",
             produce_blocked, consume_blocked, query_passed, wrong_state_finishes);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
